### rtl/core/pdll_pkg.sv
// Package for the pooled doubly linked list: operation codes, default sizes
// and field widths. No dependencies.
`default_nettype none
package pdll_pkg;
    localparam int NODES_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int IN_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
    localparam logic [OP_W-1:0] OP_READ       = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;
endpackage
`default_nettype wire

### rtl/core/pdll_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pdll_pkg for field widths.
`default_nettype none
interface pdll_req_if;
    import pdll_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [POS_W-1:0]     position;
    logic [IN_DATA_W-1:0] data_in;
    modport source (output valid, operation, position, data_in, input ready);
    modport sink   (input valid, operation, position, data_in, output ready);
endinterface

interface pdll_rsp_if;
    import pdll_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [IN_DATA_W-1:0] data_out;
    logic [POS_W-1:0]     count;
    modport source (output valid, ok, data_out, count, input ready);
    modport sink   (input valid, ok, data_out, count, output ready);
endinterface
`default_nettype wire

### rtl/core/pdll_mem.sv
// Node store: next link, previous link and payload in one synchronous memory
// with one write port and one registered read port. Depends on nothing.
`default_nettype none
module pdll_mem #(
    parameter int AW = 6,
    parameter int W  = 46
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/pooled_doubly_linked_list.sv
// Pooled doubly linked list in a fixed pool of NODES nodes. One request is
// handled at a time. A push or insert first scans the in-use marks for a free
// node, one node per cycle; insert, delete and read also walk the links
// through the node memory, one hop at a time over its single registered read
// port. The response sits in an output register and is held until taken.
// No clearing pass is needed after reset.
`default_nettype none
module pooled_doubly_linked_list #(
    parameter int NODES      = pdll_pkg::NODES_DEF,
    parameter int DATA_WIDTH = pdll_pkg::DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdll_req_if.sink  i_req,
    pdll_rsp_if.source o_rsp
);
    import pdll_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int LW = AW + 1;       // holds node indices and the none marker
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int MW = 2 * LW + DATA_WIDTH;
    localparam logic [LW-1:0] NIL = LW'(NODES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_WRD   = 4'd3;  // walk: issue read
    localparam logic [3:0] S_WWAIT = 4'd4;  // walk: data returns
    localparam logic [3:0] S_W1    = 4'd5;  // write step one
    localparam logic [3:0] S_W2    = 4'd6;
    localparam logic [3:0] S_W3    = 4'd7;
    localparam logic [3:0] S_RSP   = 4'd8;
    localparam logic [3:0] S_RDN   = 4'd9;  // read of a neighbor node
    localparam logic [3:0] S_RDNW  = 4'd10;

    logic [3:0]            r_state;
    logic [OP_W-1:0]       r_op;
    logic [CW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_din;
    logic [NODES-1:0]      r_used;
    logic [LW-1:0]         r_head, r_tail, r_len;
    logic [LW-1:0]         r_scan;       // free node found, or counter
    logic [LW-1:0]         r_cur, r_steps;
    logic [LW-1:0]         r_pv, r_nx;
    logic                  r_ok;
    logic [IN_DATA_W-1:0]  r_dout;
    logic                  r_vld;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;
    logic [LW-1:0] rd_next, rd_prev;
    logic [DATA_WIDTH-1:0] rd_pay;

    pdll_mem #(.AW(AW), .W(MW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    assign rd_next = rdata[MW-1 -: LW];
    assign rd_prev = rdata[MW-LW-1 -: LW];
    assign rd_pay  = rdata[DATA_WIDTH-1:0];

    assign i_req.ready    = (r_state == S_IDLE) && !r_vld;
    assign o_rsp.valid    = r_vld;
    assign o_rsp.ok       = r_ok;
    assign o_rsp.data_out = r_dout;
    assign o_rsp.count    = POS_W'(r_len);

    // Per-request kind of structural update, decided at dispatch.
    localparam logic [2:0] K_FRONT = 3'd0, K_BACK = 3'd1, K_DFRONT = 3'd2;
    localparam logic [2:0] K_DBACK = 3'd3, K_INS = 3'd4, K_DEL = 3'd5, K_READ = 3'd6;
    logic [2:0] r_kind;

    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = r_cur[AW-1:0];
        case (r_state)
            S_W1: begin
                we = (r_kind == K_FRONT) || (r_kind == K_BACK) || (r_kind == K_INS);
                waddr = r_scan[AW-1:0];
                wdata = {r_nx, r_pv, r_din};
            end
            S_W2, S_W3: begin
                we = 1'b1;
                waddr = r_cur[AW-1:0];
                wdata = {r_nx, r_pv, rd_pay};
            end
            default: ;
        endcase
    end

    // Neighbor patch: r_cur is the node to rewrite, its old word is read first.
    logic [LW-1:0] r_set_val;
    logic          r_set_next;
    logic          r_second;     // a second neighbor to patch
    logic [LW-1:0] r_cur2, r_val2;
    logic          r_next2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_len   <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_op  <= i_req.operation;
                    r_pos <= CW'(i_req.position);
                    r_din <= DATA_WIDTH'(i_req.data_in);
                    r_scan <= '0;
                    r_ok  <= 1'b0;
                    r_dout <= '0;
                    r_second <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Only adding operations scan; others skip at once.
                    if (!(r_op == OP_PUSH_FRONT || r_op == OP_PUSH_BACK ||
                          r_op == OP_INSERT) || r_scan == NIL ||
                        !r_used[r_scan[AW-1:0]]) begin
                        r_state <= S_DISP;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DISP: begin
                    // Front and back adds set the links of the new node here.
                    if (r_op == OP_PUSH_FRONT || (r_op == OP_INSERT &&
                        (r_len == '0 || r_pos == '0))) begin
                        r_pv <= NIL; r_nx <= r_head;
                    end else if (r_op != OP_INSERT || r_pos >= CW'(r_len)) begin
                        r_pv <= r_tail; r_nx <= NIL;
                    end
                    r_state <= S_RSP;
                    case (r_op)
                        OP_PUSH_FRONT: if (r_scan != NIL) begin
                            r_kind <= K_FRONT; r_state <= S_W1;
                        end
                        OP_PUSH_BACK: if (r_scan != NIL) begin
                            r_kind <= K_BACK; r_state <= S_W1;
                        end
                        OP_INSERT: if (r_scan != NIL) begin
                            if (r_len == '0 || r_pos == '0) begin
                                r_kind <= K_FRONT; r_state <= S_W1;
                            end else if (r_pos >= CW'(r_len)) begin
                                r_kind <= K_BACK; r_state <= S_W1;
                            end else begin
                                r_kind <= K_INS; r_cur <= r_head;
                                r_steps <= LW'(r_pos - 1'b1); r_state <= S_WRD;
                            end
                        end
                        OP_POP_FRONT: if (r_len != '0) begin
                            r_kind <= K_DFRONT; r_cur <= r_head; r_state <= S_WRD;
                            r_steps <= '0;
                        end
                        OP_POP_BACK: if (r_len != '0) begin
                            r_kind <= K_DBACK; r_cur <= r_tail; r_state <= S_WRD;
                            r_steps <= '0;
                        end
                        OP_DELETE: if (r_len != '0) begin
                            r_steps <= '0;
                            if (r_pos == '0) begin
                                r_kind <= K_DFRONT; r_cur <= r_head;
                            end else if (r_pos >= CW'(r_len - 1'b1)) begin
                                r_kind <= K_DBACK; r_cur <= r_tail;
                            end else begin
                                r_kind <= K_DEL; r_cur <= r_head;
                                r_steps <= LW'(r_pos);
                            end
                            r_state <= S_WRD;
                        end
                        OP_READ: if (r_pos < CW'(r_len)) begin
                            r_kind <= K_READ; r_cur <= r_head;
                            r_steps <= LW'(r_pos); r_state <= S_WRD;
                        end
                        default: begin
                            r_used <= '0; r_head <= NIL; r_tail <= NIL;
                            r_len <= '0; r_ok <= 1'b1;
                        end
                    endcase
                end
                S_WRD: r_state <= S_WWAIT;
                S_WWAIT: begin
                    if (r_steps != '0) begin
                        r_cur <= rd_next; r_steps <= r_steps - 1'b1;
                        r_state <= S_WRD;
                    end else begin
                        // r_cur is the target node, rdata its word.
                        r_ok <= 1'b1;
                        case (r_kind)
                            K_READ: begin
                                r_dout <= IN_DATA_W'(rd_pay);
                                r_state <= S_RSP;
                            end
                            K_INS: begin
                                // new node between r_cur and its next
                                r_pv <= r_cur; r_nx <= rd_next;
                                r_set_val <= r_scan; r_set_next <= 1'b1;
                                r_second <= 1'b1; r_cur2 <= rd_next;
                                r_val2 <= r_scan; r_next2 <= 1'b0;
                                r_used[r_scan[AW-1:0]] <= 1'b1;
                                r_len <= r_len + 1'b1;
                                r_state <= S_W1;
                            end
                            default: begin
                                // removal of r_cur
                                r_used[r_cur[AW-1:0]] <= 1'b0;
                                r_len <= r_len - 1'b1;
                                if (rd_prev == NIL || r_kind == K_DFRONT)
                                    r_head <= rd_next;
                                if (rd_next == NIL || r_kind == K_DBACK)
                                    r_tail <= rd_prev;
                                r_second <= 1'b0;
                                if (r_kind == K_DFRONT) begin
                                    r_cur <= rd_next; r_set_val <= NIL;
                                    r_set_next <= 1'b0;
                                    r_state <= (rd_next == NIL) ? S_RSP : S_RDN;
                                end else if (r_kind == K_DBACK) begin
                                    r_cur <= rd_prev; r_set_val <= NIL;
                                    r_set_next <= 1'b1;
                                    r_state <= (rd_prev == NIL) ? S_RSP : S_RDN;
                                end else begin
                                    r_cur <= rd_prev; r_set_val <= rd_next;
                                    r_set_next <= 1'b1; r_second <= 1'b1;
                                    r_cur2 <= rd_next; r_val2 <= rd_prev;
                                    r_next2 <= 1'b0; r_state <= S_RDN;
                                end
                            end
                        endcase
                    end
                end
                S_W1: begin
                    // Write the new node (kinds front, back and insert).
                    r_ok <= 1'b1;
                    if (r_kind == K_FRONT) begin
                        r_used[r_scan[AW-1:0]] <= 1'b1;
                        r_len <= r_len + 1'b1;
                        r_head <= r_scan;
                        if (r_head == NIL) begin
                            r_tail <= r_scan; r_state <= S_RSP;
                        end else begin
                            r_cur <= r_head; r_set_val <= r_scan;
                            r_set_next <= 1'b0; r_state <= S_RDN;
                        end
                    end else if (r_kind == K_BACK) begin
                        r_used[r_scan[AW-1:0]] <= 1'b1;
                        r_len <= r_len + 1'b1;
                        r_tail <= r_scan;
                        if (r_tail == NIL) begin
                            r_head <= r_scan; r_state <= S_RSP;
                        end else begin
                            r_cur <= r_tail; r_set_val <= r_scan;
                            r_set_next <= 1'b1; r_state <= S_RDN;
                        end
                    end else begin
                        r_cur <= r_pv; r_state <= S_RDN;
                    end
                end
                S_RDN: r_state <= S_RDNW;
                S_RDNW: begin
                    r_nx <= r_set_next ? r_set_val : rd_next;
                    r_pv <= r_set_next ? rd_prev : r_set_val;
                    r_state <= S_W2;
                end
                S_W2: begin
                    if (r_second) begin
                        r_second <= 1'b0; r_cur <= r_cur2;
                        r_set_val <= r_val2; r_set_next <= r_next2;
                        r_state <= S_RDN;
                    end else begin
                        r_state <= S_RSP;
                    end
                end
                S_RSP: begin
                    r_vld <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(NODES)) else $error("length past pool size");
    a_empty_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_len == '0) |-> (r_head == NIL && r_tail == NIL))
        else $error("empty list with live pointers");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !o_rsp.ready) |=> (r_vld && $stable(r_dout)))
        else $error("response lost while stalled");
endmodule
`default_nettype wire
